/* rtl/sacl_pkg.sv */
package sacl_pkg;

    // Fixed field widths
    localparam int ADDR_W  = 32;
    localparam int TAG_W   = 32;
    localparam int STAMP_W = 32;
    localparam int CNT_W   = 32;

    // One cache line entry: {valid, tag, stamp}
    localparam int ENTRY_W = 1 + TAG_W + STAMP_W;

    // Default geometry
    localparam int DEF_MAX_SETS = 64;
    localparam int DEF_WAYS     = 8;

    // Configuration register widths
    localparam int SIB_W      = 3;
    localparam int BOB_W      = 5;
    localparam int WIU_W      = 4;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 2;

    // Raw set index before folding into the set array
    localparam int RAW_SET_W  = (1 << SIB_W) - 1;
    localparam int RAW_SET_N  = 1 << RAW_SET_W;

    // Stream widths
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 104;

    // Commands
    localparam logic [1:0] CMD_FETCH  = 2'd0;
    localparam logic [1:0] CMD_LOAD   = 2'd1;
    localparam logic [1:0] CMD_STORE  = 2'd2;
    localparam logic [1:0] CMD_MODIFY = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

endpackage

/* rtl/sacl_ram.sv */
module sacl_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/set_assoc_cache_lru_lookup_unit.sv */
// Channel   Direction  Ports                       Contents (lowest bit first)
// s_axis    in         tvalid/tready/tdata/tuser   tdata: address[31:0]; tuser: command[1:0]
// m_axis    out        tvalid/tready/tdata         tdata: looked_up, hit, evicted, second_hit,
//                                                  total_hits, total_misses, total_evictions
// cfg       in         cfg_wr_en/index/wdata       0 set_index_bits, 1 block_offset_bits,
//                                                  2 ways_in_use
//
// A fetch goes from idle to the result step; a data access goes through split, one tag/stamp
// read per way through the line memory's single read port, drain, write, result and idle.
// After reset the line memory is swept clear, one entry per cycle; during the sweep
// s_axis_tready stays low, while configuration writes are taken.
// A result waits in the output register; the next transaction is accepted meanwhile, and the
// sequencer only stalls at its result step while that register is still full.
module set_assoc_cache_lru_lookup_unit
    import sacl_pkg::*;
#(
    parameter int MAX_SETS = DEF_MAX_SETS,
    parameter int WAYS     = DEF_WAYS
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // address[31:0]
    input  logic [S_TUSER_W-1:0]  s_axis_tuser,   // command[1:0]

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // looked_up[0], hit[1], evicted[2],
                                                  // second_hit[3], total_hits[35:4],
                                                  // total_misses[67:36],
                                                  // total_evictions[99:68], zero[103:100]

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int MEM_DEPTH = MAX_SETS * WAYS;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WCNT_W    = $clog2(WAYS + 1);

    // Fold a raw set index into the set array
    function automatic logic [RAW_SET_N*SET_W-1:0] build_set_map();
        logic [RAW_SET_N*SET_W-1:0] map;
        map = '0;
        for (int i = 0; i < RAW_SET_N; i++) begin
            map[i*SET_W +: SET_W] = SET_W'(i % MAX_SETS);
        end
        return map;
    endfunction

    localparam logic [RAW_SET_N*SET_W-1:0] SET_MAP = build_set_map();

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPLIT,
        ST_SCAN,
        ST_WRITE,
        ST_RESULT
    } state_t;

    // Configuration
    logic [SIB_W-1:0] sib_reg;
    logic [BOB_W-1:0] bob_reg;
    logic [WIU_W-1:0] wiu_reg;

    // Control state
    state_t              state_reg, state_next;
    logic [MEM_AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [WCNT_W-1:0]   rd_cnt_reg, rd_cnt_next;
    logic                pend_reg, pend_next;
    logic                m_valid_reg, m_valid_next;
    logic [STAMP_W-1:0]  ts_reg, ts_next;
    logic [CNT_W-1:0]    hits_reg, hits_next;
    logic [CNT_W-1:0]    misses_reg, misses_next;
    logic [CNT_W-1:0]    evicts_reg, evicts_next;

    // Per-transaction payload
    logic [1:0]          cmd_reg, cmd_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    logic [MEM_AW-1:0]   base_reg, base_next;
    logic [WAY_W-1:0]    pend_way_reg, pend_way_next;
    logic                hit_found_reg, hit_found_next;
    logic [WAY_W-1:0]    hit_way_reg, hit_way_next;
    logic                inv_found_reg, inv_found_next;
    logic [WAY_W-1:0]    inv_way_reg, inv_way_next;
    logic [WAY_W-1:0]    vic_way_reg, vic_way_next;
    logic [STAMP_W-1:0]  vic_stamp_reg, vic_stamp_next;
    logic                looked_reg, looked_next;
    logic                cur_hit_reg, cur_hit_next;
    logic                cur_evict_reg, cur_evict_next;
    logic                cur_hit2_reg, cur_hit2_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    // Line memory access
    logic                ram_we;
    logic [MEM_AW-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [MEM_AW-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic                rd_valid;
    logic [TAG_W-1:0]    rd_tag;
    logic [STAMP_W-1:0]  rd_stamp;

    // Address split and effective way count
    logic [ADDR_W-1:0]    shifted;
    logic [RAW_SET_W-1:0] raw_set;
    logic [SET_W-1:0]     set_idx;
    logic [TAG_W-1:0]     split_tag;
    logic [MEM_AW-1:0]    split_base;
    logic [4:0]           wiu_ext;
    logic [WCNT_W-1:0]    eff_ways;
    logic                 is_mod;
    logic                 out_free;
    logic [WAY_W-1:0]     way_sel;

    sacl_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (MEM_DEPTH)
    ) u_lines (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_valid = ram_rdata[ENTRY_W-1];
    assign rd_tag   = ram_rdata[STAMP_W +: TAG_W];
    assign rd_stamp = ram_rdata[STAMP_W-1:0];

    assign shifted    = addr_reg >> bob_reg;
    assign raw_set    = shifted[RAW_SET_W-1:0] & ~({RAW_SET_W{1'b1}} << sib_reg);
    assign set_idx    = SET_MAP[raw_set*SET_W +: SET_W];
    assign split_tag  = shifted >> sib_reg;
    assign split_base = MEM_AW'(set_idx) * MEM_AW'(WAYS);

    // Clamp ways_in_use to 1..WAYS
    assign wiu_ext = {1'b0, wiu_reg};
    always_comb begin
        priority if (wiu_ext == 5'd0) begin
            eff_ways = WCNT_W'(1);
        end else if (wiu_ext > 5'(WAYS)) begin
            eff_ways = WCNT_W'(WAYS);
        end else begin
            eff_ways = wiu_ext[WCNT_W-1:0];
        end
    end

    assign is_mod   = (cmd_reg == CMD_MODIFY);
    assign out_free = !m_valid_reg || m_axis_tready;

    // Hit way first, then lowest free way, then LRU victim
    always_comb begin
        priority if (hit_found_reg) begin
            way_sel = hit_way_reg;
        end else if (inv_found_reg) begin
            way_sel = inv_way_reg;
        end else begin
            way_sel = vic_way_reg;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        rd_cnt_next    = rd_cnt_reg;
        pend_next      = pend_reg;
        m_valid_next   = m_valid_reg;
        ts_next        = ts_reg;
        hits_next      = hits_reg;
        misses_next    = misses_reg;
        evicts_next    = evicts_reg;
        cmd_next       = cmd_reg;
        addr_next      = addr_reg;
        tag_next       = tag_reg;
        base_next      = base_reg;
        pend_way_next  = pend_way_reg;
        hit_found_next = hit_found_reg;
        hit_way_next   = hit_way_reg;
        inv_found_next = inv_found_reg;
        inv_way_next   = inv_way_reg;
        vic_way_next   = vic_way_reg;
        vic_stamp_next = vic_stamp_reg;
        looked_next    = looked_reg;
        cur_hit_next   = cur_hit_reg;
        cur_evict_next = cur_evict_reg;
        cur_hit2_next  = cur_hit2_reg;
        m_data_next    = m_data_reg;

        ram_we    = 1'b0;
        ram_waddr = clr_cnt_reg;
        ram_wdata = '0;
        ram_raddr = base_reg + MEM_AW'(rd_cnt_reg[WAY_W-1:0]);

        // Drop the result once taken
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                if (clr_cnt_reg == MEM_AW'(MEM_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + MEM_AW'(1);
                end
            end

            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd_next       = s_axis_tuser;
                    addr_next      = s_axis_tdata;
                    looked_next    = (s_axis_tuser != CMD_FETCH);
                    cur_hit_next   = 1'b0;
                    cur_evict_next = 1'b0;
                    cur_hit2_next  = 1'b0;
                    state_next     = (s_axis_tuser == CMD_FETCH) ? ST_RESULT : ST_SPLIT;
                end
            end

            ST_SPLIT: begin
                tag_next       = split_tag;
                base_next      = split_base;
                rd_cnt_next    = '0;
                pend_next      = 1'b0;
                hit_found_next = 1'b0;
                inv_found_next = 1'b0;
                state_next     = ST_SCAN;
            end

            ST_SCAN: begin
                // Issue one way read per cycle
                if (rd_cnt_reg < eff_ways) begin
                    rd_cnt_next   = rd_cnt_reg + WCNT_W'(1);
                    pend_next     = 1'b1;
                    pend_way_next = rd_cnt_reg[WAY_W-1:0];
                end else begin
                    pend_next = 1'b0;
                end
                // Check the way read last cycle
                if (pend_reg) begin
                    if (rd_valid && (rd_tag == tag_reg) && !hit_found_reg) begin
                        hit_found_next = 1'b1;
                        hit_way_next   = pend_way_reg;
                    end
                    if (!rd_valid && !inv_found_reg) begin
                        inv_found_next = 1'b1;
                        inv_way_next   = pend_way_reg;
                    end
                    if ((pend_way_reg == '0) || (vic_stamp_reg > rd_stamp)) begin
                        vic_way_next   = pend_way_reg;
                        vic_stamp_next = rd_stamp;
                    end
                end
                if ((rd_cnt_reg == eff_ways) && !pend_reg) begin
                    state_next = ST_WRITE;
                end
            end

            ST_WRITE: begin
                // A modify's second lookup always hits the same line one stamp later
                ram_we    = 1'b1;
                ram_waddr = base_reg + MEM_AW'(way_sel);
                ram_wdata = {1'b1, tag_reg, ts_reg + STAMP_W'(is_mod)};
                hits_next = hits_reg + CNT_W'(hit_found_reg) + CNT_W'(is_mod);
                if (!hit_found_reg) begin
                    misses_next = misses_reg + CNT_W'(1);
                end
                if (!hit_found_reg && !inv_found_reg) begin
                    evicts_next = evicts_reg + CNT_W'(1);
                end
                cur_hit_next   = hit_found_reg;
                cur_evict_next = !hit_found_reg && !inv_found_reg;
                cur_hit2_next  = is_mod;
                state_next     = ST_RESULT;
            end

            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'b0, evicts_reg, misses_reg, hits_reg,
                                    cur_hit2_reg, cur_evict_reg, cur_hit_reg, looked_reg};
                    ts_next      = ts_reg + STAMP_W'(1);
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and totals
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            rd_cnt_reg  <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            ts_reg      <= '0;
            hits_reg    <= '0;
            misses_reg  <= '0;
            evicts_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            rd_cnt_reg  <= rd_cnt_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            ts_reg      <= ts_next;
            hits_reg    <= hits_next;
            misses_reg  <= misses_next;
            evicts_reg  <= evicts_next;
        end
    end

    // Transaction payload
    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        addr_reg      <= addr_next;
        tag_reg       <= tag_next;
        base_reg      <= base_next;
        pend_way_reg  <= pend_way_next;
        hit_found_reg <= hit_found_next;
        hit_way_reg   <= hit_way_next;
        inv_found_reg <= inv_found_next;
        inv_way_reg   <= inv_way_next;
        vic_way_reg   <= vic_way_next;
        vic_stamp_reg <= vic_stamp_next;
        looked_reg    <= looked_next;
        cur_hit_reg   <= cur_hit_next;
        cur_evict_reg <= cur_evict_next;
        cur_hit2_reg  <= cur_hit2_next;
        m_data_reg    <= m_data_next;
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sib_reg <= '0;
            bob_reg <= '0;
            wiu_reg <= WIU_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SET_BITS:   sib_reg <= cfg_wdata[SIB_W-1:0];
                CFG_BLOCK_BITS: bob_reg <= cfg_wdata[BOB_W-1:0];
                CFG_WAYS:       wiu_reg <= cfg_wdata[WIU_W-1:0];
                default: begin
                    // hold: index beyond the register list
                end
            endcase
        end
    end

endmodule

/* sim/tb_set_assoc_cache_lru_lookup_unit.sv */
module tb_set_assoc_cache_lru_lookup_unit
    import sacl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SETS = DEF_MAX_SETS;
    localparam int NUM_WAYS = DEF_WAYS;
    localparam int NUM_LINES = NUM_SETS * NUM_WAYS;
    localparam int PHASES = 8;
    localparam int ACCESSES_PER_PHASE = 166;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int POOL_N = 16;

    // Register index past the end of the list; the block must ignore it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // One result, laid out as on m_axis_tdata (looked_up in bit 0)
    typedef struct packed {
        logic [3:0]  pad;
        logic [31:0] evictions;
        logic [31:0] misses;
        logic [31:0] hits;
        logic        second_hit;
        logic        evicted;
        logic        hit;
        logic        looked_up;
    } lookup_result_t;

    typedef enum bit {ROW_ACCESS, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [1:0]            cmd;
        logic [31:0]           addr;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        bit                    typed;
        lookup_result_t        res;
    } stim_row_t;

    typedef struct packed {
        logic [SIB_W-1:0] set_bits;
        logic [BOB_W-1:0] block_bits;
        logic [WIU_W-1:0] ways;
    } cache_geometry_t;

    // Geometries of the random part, extremes and out-of-range values included
    localparam cache_geometry_t GEOMETRIES [PHASES] = '{
        '{3'd0, 5'd0,  4'd1},
        '{3'd6, 5'd25, 4'd8},
        '{3'd7, 5'd31, 4'd15},
        '{3'd3, 5'd5,  4'd0},
        '{3'd2, 5'd4,  4'd4},
        '{3'd1, 5'd2,  4'd2},
        '{3'd6, 5'd0,  4'd9},
        '{3'd4, 5'd3,  4'd8}
    };

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;   // address[31:0]
    logic [S_TUSER_W-1:0]  s_axis_tuser = '0;   // command[1:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    logic [M_TDATA_W-1:0]  m_axis_tdata;        // looked_up, hit, evicted, second_hit,
                                                // total_hits, total_misses, total_evictions
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Shadow copy of the cache state and its registers
    bit              line_ok [NUM_LINES];
    logic [31:0]     line_tag_q [NUM_LINES];
    logic [31:0]     line_used [NUM_LINES];
    logic [31:0]     now_stamp;
    logic [31:0]     hit_total;
    logic [31:0]     miss_total;
    logic [31:0]     evict_total;
    logic [SIB_W-1:0] cur_set_bits;
    logic [BOB_W-1:0] cur_block_bits;
    logic [WIU_W-1:0] cur_ways;

    lookup_result_t  expected_results [$];
    lookup_result_t  seen_res;
    lookup_result_t  due_res;
    stim_row_t       directed_rows [$];

    logic [31:0]     recent_addr [POOL_N] = '{default: 32'd0};
    int              recent_head = 0;
    logic [31:0]     tag_base = '0;

    bit              gaps_on = 1'b1;
    bit              quiet = 1'b0;
    int              error_count = 0;
    int              result_count = 0;
    int              access_count = 0;
    int              fetch_count = 0;
    int              write_count = 0;
    int              hits_seen = 0;
    int              evictions_seen = 0;
    int              cycle_count = 0;

    set_assoc_cache_lru_lookup_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Clamp the way count the same way the block does
    function automatic int unsigned active_ways();
        int unsigned w;
        w = cur_ways;
        if (w < 1) w = 1;
        if (w > NUM_WAYS) w = NUM_WAYS;
        return w;
    endfunction

    // Search one set, then fill a free way or replace the least recently used one
    function automatic void probe_set(input int unsigned set_idx, input logic [31:0] tag,
                                      input logic [31:0] stamp, output bit was_hit,
                                      output bit was_evict);
        int unsigned n;
        int unsigned base;
        int unsigned victim;
        int unsigned i;
        n = active_ways();
        base = set_idx * NUM_WAYS;
        was_hit = 1'b0;
        was_evict = 1'b0;
        for (i = 0; i < n; i++) begin
            if (line_ok[base+i] && line_tag_q[base+i] == tag) begin
                hit_total++;
                line_used[base+i] = stamp;
                was_hit = 1'b1;
                return;
            end
        end
        miss_total++;
        for (i = 0; i < n; i++) begin
            if (!line_ok[base+i]) begin
                line_ok[base+i] = 1'b1;
                line_tag_q[base+i] = tag;
                line_used[base+i] = stamp;
                return;
            end
        end
        victim = 0;
        for (i = 1; i < n; i++) begin
            if (line_used[base+victim] > line_used[base+i]) victim = i;
        end
        evict_total++;
        line_tag_q[base+victim] = tag;
        line_used[base+victim] = stamp;
        was_evict = 1'b1;
    endfunction

    // Advance the shadow cache by one access and return the result it should give
    function automatic lookup_result_t predict_access(input logic [1:0] cmd,
                                                      input logic [31:0] addr);
        logic [63:0]    shifted;
        logic [63:0]    mask;
        int unsigned    set_idx;
        logic [31:0]    tag;
        bit             h, ev, h2, ev2;
        lookup_result_t r;
        r = '0;
        if (cmd != CMD_FETCH) begin
            shifted = {32'd0, addr} >> cur_block_bits;
            mask = (64'd1 << cur_set_bits) - 64'd1;
            set_idx = int'((shifted & mask) % NUM_SETS);
            tag = shifted[31:0];
            tag = 32'(shifted >> cur_set_bits);
            r.looked_up = 1'b1;
            probe_set(set_idx, tag, now_stamp, h, ev);
            r.hit = h;
            r.evicted = ev;
            if (cmd == CMD_MODIFY) begin
                probe_set(set_idx, tag, now_stamp + 32'd1, h2, ev2);
                r.second_hit = h2;
            end
        end
        now_stamp++;
        r.hits = hit_total;
        r.misses = miss_total;
        r.evictions = evict_total;
        return r;
    endfunction

    function automatic lookup_result_t mk_res(input bit lu, input bit h, input bit ev,
                                              input bit h2, input logic [31:0] th,
                                              input logic [31:0] tm, input logic [31:0] te);
        lookup_result_t r;
        r = '0;
        r.looked_up = lu;
        r.hit = h;
        r.evicted = ev;
        r.second_hit = h2;
        r.hits = th;
        r.misses = tm;
        r.evictions = te;
        return r;
    endfunction

    function automatic stim_row_t access_row(input logic [1:0] cmd, input logic [31:0] addr);
        stim_row_t row;
        row = '{kind: ROW_ACCESS, cmd: cmd, addr: addr, reg_idx: '0, reg_val: '0,
                typed: 1'b0, res: '0};
        return row;
    endfunction

    function automatic stim_row_t known_row(input logic [1:0] cmd, input logic [31:0] addr,
                                            input lookup_result_t res);
        stim_row_t row;
        row = access_row(cmd, addr);
        row.typed = 1'b1;
        row.res = res;
        return row;
    endfunction

    function automatic stim_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] val);
        stim_row_t row;
        row = '{kind: ROW_WRITE, cmd: CMD_FETCH, addr: '0, reg_idx: idx, reg_val: val,
                typed: 1'b0, res: '0};
        return row;
    endfunction

    // Mostly data accesses, with loads, stores and modifies in roughly equal share
    function automatic logic [1:0] pick_command();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r <= 1) return CMD_FETCH;
        if (r <= 4) return CMD_LOAD;
        if (r <= 6) return CMD_STORE;
        return CMD_MODIFY;
    endfunction

    // Build addresses that crowd a few sets with a few tags, reuse recent ones,
    // or are fully random
    function automatic logic [31:0] make_addr();
        logic [63:0] tagv;
        logic [63:0] setv;
        logic [63:0] offv;
        logic [63:0] full;
        int unsigned mode;
        logic [31:0] a;
        mode = $urandom_range(0, 9);
        if (mode <= 5) begin
            tagv = 64'(tag_base + 32'($urandom_range(0, active_ways() + 2)));
            setv = 64'($urandom) & ((64'd1 << cur_set_bits) - 64'd1);
            if ($urandom_range(0, 1) == 1) setv = setv & 64'd3;
            offv = 64'($urandom) & ((64'd1 << cur_block_bits) - 64'd1);
            full = (tagv << (int'(cur_set_bits) + int'(cur_block_bits)))
                 | (setv << cur_block_bits) | offv;
            a = full[31:0];
        end else if (mode <= 7) begin
            a = recent_addr[$urandom_range(0, POOL_N - 1)];
        end else begin
            a = $urandom;
        end
        recent_addr[recent_head] = a;
        recent_head = (recent_head + 1) % POOL_N;
        return a;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at result %0d, %s: got %0h, expected %0h",
                 result_count, what, got, want);
        error_count++;
    endtask

    task automatic compare_field(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // Hand one access to the block and queue what it should answer
    task automatic send_access(input logic [1:0] cmd, input logic [31:0] addr,
                               input bit typed, input lookup_result_t typed_res);
        lookup_result_t want;
        if (gaps_on && !quiet && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= addr;
        s_axis_tuser <= cmd;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        want = predict_access(cmd, addr);
        if (typed) want = typed_res;
        expected_results.push_back(want);
        if (cmd == CMD_FETCH) fetch_count++;
        else access_count++;
        @(negedge aclk);
    endtask

    // Hold the sender until every queued result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(negedge aclk); while (expected_results.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_SET_BITS:   cur_set_bits = val[SIB_W-1:0];
            CFG_BLOCK_BITS: cur_block_bits = val[BOB_W-1:0];
            CFG_WAYS:       cur_ways = val[WIU_W-1:0];
            default:        ;
        endcase
        write_count++;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Check each result against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            seen_res = lookup_result_t'(m_axis_tdata);
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected", seen_res.hits, '0);
            end else begin
                due_res = expected_results.pop_front();
                compare_field("looked_up", 32'(seen_res.looked_up), 32'(due_res.looked_up));
                compare_field("hit", 32'(seen_res.hit), 32'(due_res.hit));
                compare_field("evicted", 32'(seen_res.evicted), 32'(due_res.evicted));
                compare_field("second_hit", 32'(seen_res.second_hit),
                              32'(due_res.second_hit));
                compare_field("total_hits", seen_res.hits, due_res.hits);
                compare_field("total_misses", seen_res.misses, due_res.misses);
                compare_field("total_evictions", seen_res.evictions, due_res.evictions);
                compare_field("padding", 32'(seen_res.pad), 32'(due_res.pad));
            end
            if (seen_res.hit) hits_seen++;
            if (seen_res.evicted) evictions_seen++;
            result_count++;
        end
    end

    // Stall the result channel in bursts, with calm stretches in between
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!quiet) begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        m_axis_tready <= 1'b0;
                        repeat ($urandom_range(1, 11)) @(negedge aclk);
                        m_axis_tready <= 1'b1;
                    end
                    2: repeat ($urandom_range(30, 80)) @(negedge aclk);
                    default: ;
                endcase
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int              p;
        int              n_access;
        logic [1:0]      cmd;
        cache_geometry_t geom;
        stim_row_t       row;

        // Shadow state after reset
        for (int i = 0; i < NUM_LINES; i++) line_ok[i] = 1'b0;
        now_stamp = '0;
        hit_total = '0;
        miss_total = '0;
        evict_total = '0;
        cur_set_bits = '0;
        cur_block_bits = '0;
        cur_ways = 4'd1;

        // Directed rows: reset geometry first (one way, one set, byte blocks)
        directed_rows.push_back(known_row(CMD_FETCH, 32'h0000_0000,
            mk_res(1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0)));
        directed_rows.push_back(known_row(CMD_LOAD, 32'h0000_0000,
            mk_res(1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd1, 32'd0)));
        directed_rows.push_back(known_row(CMD_LOAD, 32'h0000_0000,
            mk_res(1'b1, 1'b1, 1'b0, 1'b0, 32'd1, 32'd1, 32'd0)));
        directed_rows.push_back(known_row(CMD_STORE, 32'hFFFF_FFFF,
            mk_res(1'b1, 1'b0, 1'b1, 1'b0, 32'd1, 32'd2, 32'd1)));
        directed_rows.push_back(known_row(CMD_MODIFY, 32'hFFFF_FFFF,
            mk_res(1'b1, 1'b1, 1'b0, 1'b1, 32'd3, 32'd2, 32'd1)));
        directed_rows.push_back(known_row(CMD_MODIFY, 32'h0000_0000,
            mk_res(1'b1, 1'b0, 1'b1, 1'b1, 32'd4, 32'd3, 32'd2)));
        directed_rows.push_back(known_row(CMD_FETCH, 32'hFFFF_FFFF,
            mk_res(1'b0, 1'b0, 1'b0, 1'b0, 32'd4, 32'd3, 32'd2)));
        // Four ways, four sets, 16-byte blocks: fill one set, then walk the LRU order
        directed_rows.push_back(write_row(CFG_SET_BITS, 5'd2));
        directed_rows.push_back(write_row(CFG_BLOCK_BITS, 5'd4));
        directed_rows.push_back(write_row(CFG_WAYS, 5'd4));
        directed_rows.push_back(access_row(CMD_LOAD, 32'h0000_0000));
        directed_rows.push_back(access_row(CMD_LOAD, 32'h0000_0040));
        directed_rows.push_back(access_row(CMD_LOAD, 32'h0000_0080));
        directed_rows.push_back(access_row(CMD_LOAD, 32'h0000_00C0));
        directed_rows.push_back(access_row(CMD_LOAD, 32'h0000_0005));
        directed_rows.push_back(access_row(CMD_STORE, 32'h0000_0100));
        directed_rows.push_back(access_row(CMD_LOAD, 32'h0000_0040));
        directed_rows.push_back(access_row(CMD_MODIFY, 32'h0000_00C0));
        directed_rows.push_back(access_row(CMD_LOAD, 32'h0000_0010));
        // Ignored register index, zero ways, widest set and offset fields
        directed_rows.push_back(write_row(CFG_UNUSED, 5'd31));
        directed_rows.push_back(write_row(CFG_WAYS, 5'd0));
        directed_rows.push_back(write_row(CFG_SET_BITS, 5'd7));
        directed_rows.push_back(write_row(CFG_BLOCK_BITS, 5'd31));
        directed_rows.push_back(access_row(CMD_LOAD, 32'h8000_0000));
        directed_rows.push_back(access_row(CMD_LOAD, 32'h7FFF_FFFF));
        directed_rows.push_back(access_row(CMD_MODIFY, 32'hFFFF_FFFF));
        // Ways above the array size, 64 sets, no block offset
        directed_rows.push_back(write_row(CFG_WAYS, 5'd15));
        directed_rows.push_back(write_row(CFG_SET_BITS, 5'd6));
        directed_rows.push_back(write_row(CFG_BLOCK_BITS, 5'd0));
        directed_rows.push_back(access_row(CMD_LOAD, 32'hFFFF_FFFF));
        directed_rows.push_back(access_row(CMD_STORE, 32'hFFFF_FFC0));
        directed_rows.push_back(access_row(CMD_MODIFY, 32'hFFFF_FFFF));

        // Reset
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Walk the directed table
        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.kind == ROW_WRITE) begin
                drain_results();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_access(row.cmd, row.addr, row.typed, row.res);
            end
        end

        // Random phases, one geometry each; the last one runs without idling
        for (p = 0; p < PHASES; p++) begin
            geom = GEOMETRIES[p];
            drain_results();
            write_reg(CFG_SET_BITS, CFG_DATA_W'(geom.set_bits));
            write_reg(CFG_BLOCK_BITS, CFG_DATA_W'(geom.block_bits));
            write_reg(CFG_WAYS, CFG_DATA_W'(geom.ways));
            tag_base = $urandom;
            if (p == PHASES - 1) quiet = 1'b1;
            n_access = 0;
            while (n_access < ACCESSES_PER_PHASE) begin
                cmd = pick_command();
                send_access(cmd, make_addr(), 1'b0, '0);
                n_access++;
                if (p == 1 && n_access == ACCESSES_PER_PHASE / 2) drain_results();
                if ($urandom_range(0, 39) == 0) gaps_on = !gaps_on;
            end
        end

        // Let the last results arrive, then watch for strays
        drain_results();
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Ran %0d data accesses and %0d fetches across %0d register writes",
                 access_count, fetch_count, write_count);
        $display("Checked %0d results: %0d hits, %0d evictions, %0d mismatches",
                 result_count, hits_seen, evictions_seen, error_count);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
